>>> design/aarm_pkg.sv
// Package for the axis-angle rotation matrix unit: shared types, fixed-point constants,
// the CORDIC arctangent table and the back-end state encoding. Depends on nothing.
`default_nettype none

package aarm_pkg;

	localparam int TRIG_MAX = 32;

	localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
	localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;

	localparam logic [3:0] SQ_OPS  = 4'd3;
	localparam logic [3:0] MUL_OPS = 4'd15;
	localparam logic [3:0] OFS_OPS = 4'd9;

	typedef struct packed {
		logic signed [31:0] p1_x;
		logic signed [31:0] p1_y;
		logic signed [31:0] p1_z;
		logic [2:0]         neg;
		logic [2:0][32:0]   mag;
		logic [32:0]        big;
		logic               bad;
		logic signed [31:0] angle;
	} item_t;

	typedef struct packed {
		logic [1:0]         row_index;
		logic signed [31:0] m_col0;
		logic signed [31:0] m_col1;
		logic signed [31:0] m_col2;
		logic signed [31:0] offset;
		logic               last_row;
		logic               bad_axis;
	} row_t;

	typedef struct packed {
		logic               done;
		logic signed [31:0] cos_v;
		logic signed [31:0] sin_v;
	} trig_t;

	typedef enum logic [3:0] {
		B_IDLE, B_NORM, B_SQ, B_SQRT, B_DIV, B_TRIG, B_MUL, B_MAT, B_OFS, B_EMIT
	} back_state_t;

	function automatic logic [29:0] atan_q30(input logic [4:0] idx);
		logic [29:0] v;
		unique case (idx)
			5'd0:  v = 30'd843314856;
			5'd1:  v = 30'd497837829;
			5'd2:  v = 30'd263043836;
			5'd3:  v = 30'd133525158;
			5'd4:  v = 30'd67021686;
			5'd5:  v = 30'd33543515;
			5'd6:  v = 30'd16775850;
			5'd7:  v = 30'd8388437;
			5'd8:  v = 30'd4194282;
			5'd9:  v = 30'd2097149;
			5'd10: v = 30'd1048575;
			5'd11: v = 30'd524287;
			5'd12: v = 30'd262143;
			5'd13: v = 30'd131071;
			5'd14: v = 30'd65535;
			5'd15: v = 30'd32767;
			5'd16: v = 30'd16383;
			5'd17: v = 30'd8191;
			5'd18: v = 30'd4095;
			5'd19: v = 30'd2047;
			5'd20: v = 30'd1023;
			5'd21: v = 30'd511;
			5'd22: v = 30'd255;
			5'd23: v = 30'd127;
			5'd24: v = 30'd63;
			5'd25: v = 30'd31;
			5'd26: v = 30'd15;
			5'd27: v = 30'd7;
			5'd28: v = 30'd3;
			5'd29: v = 30'd1;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

>>> design/aarm_fifo.sv
// Small register-based queue used between the front and back ends and on the result side.
// Generic payload vector; depends on nothing.
`default_nettype none

module aarm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

>>> design/aarm_front.sv
// Front end: accepts a transaction, forms the axis direction and its magnitudes,
// and flags coincident points. Depends on aarm_pkg.
`default_nettype none

module aarm_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [31:0] p1_x,
	input  logic signed [31:0] p1_y,
	input  logic signed [31:0] p1_z,
	input  logic signed [31:0] p2_x,
	input  logic signed [31:0] p2_y,
	input  logic signed [31:0] p2_z,
	input  logic signed [31:0] turn_angle,
	input  logic               mid_full,
	output logic               mid_push,
	output aarm_pkg::item_t    mid_item
);
	import aarm_pkg::*;

	logic             valid_s1;
	item_t            item_s1;
	item_t            item_d;
	logic signed [32:0] d [3];
	logic [32:0]      mag [3];
	logic [32:0]      big01;

	always_comb begin
		d[0] = {p2_x[31], p2_x} - {p1_x[31], p1_x};
		d[1] = {p2_y[31], p2_y} - {p1_y[31], p1_y};
		d[2] = {p2_z[31], p2_z} - {p1_z[31], p1_z};
		for (int k = 0; k < 3; k++) begin
			mag[k] = d[k][32] ? unsigned'(33'sd0 - d[k]) : unsigned'(d[k]);
		end
		big01 = (mag[1] > mag[0]) ? mag[1] : mag[0];
		item_d.p1_x  = p1_x;
		item_d.p1_y  = p1_y;
		item_d.p1_z  = p1_z;
		item_d.neg   = {d[2][32], d[1][32], d[0][32]};
		item_d.mag   = {mag[2], mag[1], mag[0]};
		item_d.big   = (mag[2] > big01) ? mag[2] : big01;
		item_d.bad   = (item_d.big == '0);
		item_d.angle = turn_angle;
	end

	assign full     = valid_s1 && mid_full;
	assign mid_push = valid_s1 && !mid_full;
	assign mid_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!full) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (!full && push) begin
			item_s1 <= item_d;
		end
	end

endmodule

`default_nettype wire

>>> design/aarm_cordic.sv
// Iterative CORDIC in rotation mode giving cosine and sine of the turn angle, one step
// per cycle with quadrant folding. Depends on aarm_pkg.
`default_nettype none

module aarm_cordic #(
	parameter int ITER = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] angle,
	output aarm_pkg::trig_t    trig
);
	import aarm_pkg::*;

	localparam int N = (ITER > TRIG_MAX) ? TRIG_MAX : ITER;
	localparam logic [4:0] LAST = 5'(N - 1);
	localparam logic signed [33:0] ONE34 = 34'sd1073741824;

	logic signed [33:0] x_q, y_q, z_q;
	logic               flip_q, busy_q;
	logic [4:0]         i_q;
	logic signed [33:0] z0, zr, at, xn, yn, zn, xf, yf;
	logic               fl;

	always_comb begin
		z0 = signed'({angle[31], angle, 1'b0});
		if (z0 > HALF_PI_Q30) begin
			zr = z0 - PI_Q30;
			fl = 1'b1;
		end else if (z0 < -HALF_PI_Q30) begin
			zr = z0 + PI_Q30;
			fl = 1'b1;
		end else begin
			zr = z0;
			fl = 1'b0;
		end
		at = signed'({4'b0, atan_q30(i_q)});
		if (!z_q[33]) begin
			xn = x_q - (y_q >>> i_q);
			yn = y_q + (x_q >>> i_q);
			zn = z_q - at;
		end else begin
			xn = x_q + (y_q >>> i_q);
			yn = y_q - (x_q >>> i_q);
			zn = z_q + at;
		end
		xf = flip_q ? 34'sd0 - x_q : x_q;
		yf = flip_q ? 34'sd0 - y_q : y_q;
		trig.done  = !busy_q;
		trig.cos_v = (xf > ONE34) ? ONE_Q30 : ((xf < -ONE34) ? -ONE_Q30 : xf[31:0]);
		trig.sin_v = (yf > ONE34) ? ONE_Q30 : ((yf < -ONE34) ? -ONE_Q30 : yf[31:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			i_q    <= '0;
		end else if (busy_q) begin
			i_q <= i_q + 1'b1;
			if (i_q == LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= GAIN_Q30;
			y_q    <= '0;
			z_q    <= zr;
			flip_q <= fl;
		end else if (busy_q) begin
			x_q <= xn;
			y_q <= yn;
			z_q <= zn;
		end
	end

endmodule

`default_nettype wire

>>> design/aarm_back.sv
// Back end: normalizes the axis, takes the square root and the three divisions bit-serially,
// runs the products on one shared multiplier and emits the three rows. Depends on
// aarm_pkg and aarm_cordic.
`default_nettype none

module aarm_back #(
	parameter int TRIG_ITERATIONS = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_empty,
	input  aarm_pkg::item_t in_item,
	output logic            in_pop,
	input  logic            out_full,
	output logic            out_push,
	output aarm_pkg::row_t  out_row
);
	import aarm_pkg::*;

	localparam logic [3:0] UU = 4'd6;
	localparam logic [3:0] VV = 4'd7;
	localparam logic [3:0] WW = 4'd8;
	localparam logic [3:0] UV = 4'd9;
	localparam logic [3:0] UW = 4'd10;
	localparam logic [3:0] VW = 4'd11;
	localparam logic [3:0] WS = 4'd12;
	localparam logic [3:0] VS = 4'd13;
	localparam logic [3:0] US = 4'd14;

	back_state_t state_q, state_d;
	logic [3:0]  mc_q, ptag_q;
	logic        pv_q;
	logic [4:0]  cnt_q;
	logic [1:0]  row_q;

	item_t              item_q;
	logic [32:0]        mag_q [3];
	logic [32:0]        big_q;
	logic [63:0]        sq_q, n_q, r_q, bit_q;
	logic [61:0]        rem_q [3];
	logic [61:0]        dsh_q;
	logic [30:0]        q_q [3];
	logic signed [33:0] mr_q [15];
	logic signed [65:0] prod_q;
	logic signed [31:0] m_q [3][3];
	logic signed [64:0] acc_q [3];

	logic               load, mul_go;
	logic signed [32:0] mul_a, mul_b, omc;
	logic signed [65:0] prod_d, rnd_m;
	logic signed [33:0] mqv;
	logic signed [31:0] dir [3];
	logic signed [31:0] p1s [3];
	logic signed [31:0] cs, sn;
	logic [64:0]        rb;
	logic [63:0]        r_nx, n_nx;
	logic               ge;
	logic signed [64:0] rnd_o, t_o;
	trig_t              trig;

	function automatic logic signed [31:0] clamp_m(input logic signed [34:0] v);
		logic signed [31:0] res;
		if (v > 35'sd1073741824) begin
			res = ONE_Q30;
		end else if (v < -35'sd1073741824) begin
			res = -ONE_Q30;
		end else begin
			res = v[31:0];
		end
		return res;
	endfunction

	function automatic logic [1:0] row_of(input logic [3:0] tag);
		return (tag >= 4'd6) ? 2'd2 : ((tag >= 4'd3) ? 2'd1 : 2'd0);
	endfunction

	aarm_cordic #(.ITER(TRIG_ITERATIONS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (load),
		.angle  (in_item.angle),
		.trig   (trig)
	);

	always_comb begin
		p1s[0] = item_q.p1_x;
		p1s[1] = item_q.p1_y;
		p1s[2] = item_q.p1_z;
		for (int k = 0; k < 3; k++) begin
			dir[k] = item_q.neg[k] ? 32'sd0 - signed'({1'b0, q_q[k]})
			                       : signed'({1'b0, q_q[k]});
		end
		cs  = trig.cos_v;
		sn  = trig.sin_v;
		omc = 33'sd1073741824 - 33'(cs);

		rb   = {1'b0, r_q} + {1'b0, bit_q};
		ge   = ({1'b0, n_q} >= rb);
		r_nx = ge ? (r_q >> 1) + bit_q : (r_q >> 1);
		n_nx = ge ? n_q - rb[63:0] : n_q;

		rnd_m = prod_q + 66'sd536870912;
		mqv   = 34'(rnd_m >>> 30);
		rnd_o = acc_q[0] + 65'sd536870912;
		t_o   = rnd_o >>> 30;
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			B_SQ: begin
				case (mc_q)
					4'd0: mul_a = signed'({2'b0, mag_q[0][30:0]});
					4'd1: mul_a = signed'({2'b0, mag_q[1][30:0]});
					4'd2: mul_a = signed'({2'b0, mag_q[2][30:0]});
					default: mul_a = '0;
				endcase
				mul_b = mul_a;
			end
			B_MUL: begin
				case (mc_q)
					4'd0: begin mul_a = 33'(dir[0]); mul_b = 33'(dir[0]); end
					4'd1: begin mul_a = 33'(dir[1]); mul_b = 33'(dir[1]); end
					4'd2: begin mul_a = 33'(dir[2]); mul_b = 33'(dir[2]); end
					4'd3: begin mul_a = 33'(dir[0]); mul_b = 33'(dir[1]); end
					4'd4: begin mul_a = 33'(dir[0]); mul_b = 33'(dir[2]); end
					4'd5: begin mul_a = 33'(dir[1]); mul_b = 33'(dir[2]); end
					4'd6: begin mul_a = mr_q[0][32:0]; mul_b = omc; end
					4'd7: begin mul_a = mr_q[1][32:0]; mul_b = omc; end
					4'd8: begin mul_a = mr_q[2][32:0]; mul_b = omc; end
					4'd9: begin mul_a = mr_q[3][32:0]; mul_b = omc; end
					4'd10: begin mul_a = mr_q[4][32:0]; mul_b = omc; end
					4'd11: begin mul_a = mr_q[5][32:0]; mul_b = omc; end
					4'd12: begin mul_a = 33'(dir[2]); mul_b = 33'(sn); end
					4'd13: begin mul_a = 33'(dir[1]); mul_b = 33'(sn); end
					4'd14: begin mul_a = 33'(dir[0]); mul_b = 33'(sn); end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			B_OFS: begin
				case (mc_q)
					4'd0: begin mul_a = 33'(m_q[0][0]); mul_b = 33'(p1s[0]); end
					4'd1: begin mul_a = 33'(m_q[0][1]); mul_b = 33'(p1s[1]); end
					4'd2: begin mul_a = 33'(m_q[0][2]); mul_b = 33'(p1s[2]); end
					4'd3: begin mul_a = 33'(m_q[1][0]); mul_b = 33'(p1s[0]); end
					4'd4: begin mul_a = 33'(m_q[1][1]); mul_b = 33'(p1s[1]); end
					4'd5: begin mul_a = 33'(m_q[1][2]); mul_b = 33'(p1s[2]); end
					4'd6: begin mul_a = 33'(m_q[2][0]); mul_b = 33'(p1s[0]); end
					4'd7: begin mul_a = 33'(m_q[2][1]); mul_b = 33'(p1s[1]); end
					4'd8: begin mul_a = 33'(m_q[2][2]); mul_b = 33'(p1s[2]); end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod_d = mul_a * mul_b;
	end

	always_comb begin
		state_d = state_q;
		load    = 1'b0;
		in_pop  = 1'b0;
		out_push = 1'b0;
		mul_go  = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				in_pop = 1'b1;
				if (!in_empty) begin
					load    = 1'b1;
					state_d = in_item.bad ? B_EMIT : B_NORM;
				end
			end
			B_NORM: begin
				if (big_q[32:31] == 2'b00 && big_q[30]) begin
					state_d = B_SQ;
				end
			end
			B_SQ: begin
				mul_go = (mc_q < SQ_OPS);
				if (mc_q == SQ_OPS && !pv_q) begin
					state_d = B_SQRT;
				end
			end
			B_SQRT: begin
				if (cnt_q == 5'd31) begin
					state_d = B_DIV;
				end
			end
			B_DIV: begin
				if (cnt_q == 5'd30) begin
					state_d = B_TRIG;
				end
			end
			B_TRIG: begin
				if (trig.done) begin
					state_d = B_MUL;
				end
			end
			B_MUL: begin
				mul_go = (mc_q < MUL_OPS);
				if (mc_q == MUL_OPS && !pv_q) begin
					state_d = B_MAT;
				end
			end
			B_MAT: begin
				state_d = B_OFS;
			end
			B_OFS: begin
				mul_go = (mc_q < OFS_OPS);
				if (mc_q == OFS_OPS && !pv_q) begin
					state_d = B_EMIT;
				end
			end
			B_EMIT: begin
				out_push = 1'b1;
				if (!out_full && row_q == 2'd2) begin
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_comb begin
		out_row.row_index = row_q;
		out_row.m_col0    = m_q[0][0];
		out_row.m_col1    = m_q[0][1];
		out_row.m_col2    = m_q[0][2];
		if (t_o > 65'sd2147483647) begin
			out_row.offset = 32'sh7FFFFFFF;
		end else if (t_o < -65'sd2147483648) begin
			out_row.offset = 32'sh80000000;
		end else begin
			out_row.offset = t_o[31:0];
		end
		out_row.last_row = (row_q == 2'd2);
		out_row.bad_axis = item_q.bad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			mc_q    <= '0;
			ptag_q  <= '0;
			pv_q    <= 1'b0;
			cnt_q   <= '0;
			row_q   <= '0;
		end else begin
			state_q <= state_d;
			pv_q    <= mul_go;
			ptag_q  <= mc_q;
			if (state_d != state_q) begin
				mc_q  <= '0;
				cnt_q <= '0;
				row_q <= '0;
			end else begin
				if (mul_go) begin
					mc_q <= mc_q + 1'b1;
				end
				if (state_q == B_SQRT || state_q == B_DIV) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (out_push && !out_full) begin
					row_q <= row_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		if (load) begin
			item_q <= in_item;
			for (int k = 0; k < 3; k++) begin
				mag_q[k] <= in_item.mag[k];
				acc_q[k] <= '0;
				for (int j = 0; j < 3; j++) begin
					m_q[k][j] <= (k == j) ? ONE_Q30 : 32'sd0;
				end
			end
			big_q <= in_item.big;
			sq_q  <= '0;
		end
		if (state_q == B_NORM) begin
			if (big_q[32:31] != 2'b00) begin
				big_q <= big_q >> 1;
				for (int k = 0; k < 3; k++) begin
					mag_q[k] <= mag_q[k] >> 1;
				end
			end else if (!big_q[30]) begin
				big_q <= big_q << 1;
				for (int k = 0; k < 3; k++) begin
					mag_q[k] <= mag_q[k] << 1;
				end
			end
		end
		if (state_q == B_SQ && pv_q) begin
			sq_q <= sq_q + prod_q[63:0];
		end
		if (state_q == B_SQ && state_d == B_SQRT) begin
			n_q   <= sq_q;
			r_q   <= '0;
			bit_q <= 64'd1 << 62;
		end
		if (state_q == B_SQRT) begin
			n_q   <= n_nx;
			r_q   <= r_nx;
			bit_q <= bit_q >> 2;
			if (cnt_q == 5'd31) begin
				dsh_q <= {r_nx[31:0], 30'b0};
				for (int k = 0; k < 3; k++) begin
					rem_q[k] <= {1'b0, mag_q[k][30:0], 30'b0} + 62'(r_nx[31:1]);
				end
			end
		end
		if (state_q == B_DIV) begin
			dsh_q <= dsh_q >> 1;
			for (int k = 0; k < 3; k++) begin
				if (rem_q[k] >= dsh_q) begin
					rem_q[k] <= rem_q[k] - dsh_q;
					q_q[k]   <= {q_q[k][29:0], 1'b1};
				end else begin
					q_q[k] <= {q_q[k][29:0], 1'b0};
				end
			end
		end
		if (state_q == B_MUL && pv_q) begin
			mr_q[ptag_q] <= mqv;
		end
		if (state_q == B_MAT) begin
			m_q[0][0] <= clamp_m(35'(mr_q[UU]) + 35'(cs));
			m_q[0][1] <= clamp_m(35'(mr_q[UV]) - 35'(mr_q[WS]));
			m_q[0][2] <= clamp_m(35'(mr_q[UW]) + 35'(mr_q[VS]));
			m_q[1][0] <= clamp_m(35'(mr_q[UV]) + 35'(mr_q[WS]));
			m_q[1][1] <= clamp_m(35'(mr_q[VV]) + 35'(cs));
			m_q[1][2] <= clamp_m(35'(mr_q[VW]) - 35'(mr_q[US]));
			m_q[2][0] <= clamp_m(35'(mr_q[UW]) - 35'(mr_q[VS]));
			m_q[2][1] <= clamp_m(35'(mr_q[VW]) + 35'(mr_q[US]));
			m_q[2][2] <= clamp_m(35'(mr_q[WW]) + 35'(cs));
			for (int k = 0; k < 3; k++) begin
				acc_q[k] <= signed'({{3{p1s[k][31]}}, p1s[k], 30'b0});
			end
		end
		if (state_q == B_OFS && pv_q) begin
			acc_q[row_of(ptag_q)] <= acc_q[row_of(ptag_q)] - 65'(prod_q);
		end
		if (out_push && !out_full) begin
			m_q[0]   <= m_q[1];
			m_q[1]   <= m_q[2];
			acc_q[0] <= acc_q[1];
			acc_q[1] <= acc_q[2];
		end
	end

	a_trig_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_MUL) |-> trig.done)
		else $error("Products started before the trig result was ready.");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DIV) |-> (r_q[63:32] == 32'd0 && r_q[31:30] != 2'b00))
		else $error("Axis length out of the normalized range.");

	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		(out_push && !out_full && row_q == 2'd2) |=> (state_q == B_IDLE))
		else $error("Back end did not return to idle after the last row.");

	a_prod_used: assert property (@(posedge clk) disable iff (!arst_n)
		pv_q |-> (state_q == B_SQ || state_q == B_MUL || state_q == B_OFS))
		else $error("Multiplier result arrived outside a product phase.");

endmodule

`default_nettype wire

>>> design/axis_angle_rotation_matrix_unit.sv
// Top level of the axis-angle rotation matrix unit: front end, item queue, back end and
// result queue. Depends on aarm_pkg, aarm_fifo, aarm_front and aarm_back.
//
//   channel  | handshake          | payload
//   input    | push / full        | p1_x p1_y p1_z p2_x p2_y p2_z turn_angle
//   result   | pop / empty        | row_index m_col0 m_col1 m_col2 offset last_row bad_axis
//
// In the back end, each transaction's run time is set by the one-bit-per-cycle
// axis normalization, the 32-step square root and the 31-step dividers.
// A transaction with coincident points goes straight to emitting its rows in the back end.
// The front end and a two-entry queue accept new transactions while the back end works.
// Results wait in a four-entry queue; a full result queue stalls the back end directly.
// Reset is asynchronous and clears all control state; no clearing pass is needed.
`default_nettype none

module axis_angle_rotation_matrix_unit #(
	parameter int TRIG_ITERATIONS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [31:0] p1_x,
	input  logic signed [31:0] p1_y,
	input  logic signed [31:0] p1_z,
	input  logic signed [31:0] p2_x,
	input  logic signed [31:0] p2_y,
	input  logic signed [31:0] p2_z,
	input  logic signed [31:0] turn_angle,
	input  logic               pop,
	output logic               empty,
	output logic [1:0]         row_index,
	output logic signed [31:0] m_col0,
	output logic signed [31:0] m_col1,
	output logic signed [31:0] m_col2,
	output logic signed [31:0] offset,
	output logic               last_row,
	output logic               bad_axis
);
	import aarm_pkg::*;

	localparam int MID_DEPTH = 2;
	localparam int OUT_DEPTH = 4;

	logic  mid_push, mid_full, mid_pop, mid_empty;
	item_t mid_wdata, mid_rdata;
	logic  res_push, res_full;
	row_t  res_wdata, res_rdata;

	aarm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.p1_x       (p1_x),
		.p1_y       (p1_y),
		.p1_z       (p1_z),
		.p2_x       (p2_x),
		.p2_y       (p2_y),
		.p2_z       (p2_z),
		.turn_angle (turn_angle),
		.mid_full   (mid_full),
		.mid_push   (mid_push),
		.mid_item   (mid_wdata)
	);

	aarm_fifo #(.WIDTH($bits(item_t)), .DEPTH(MID_DEPTH)) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_wdata),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty)
	);

	aarm_back #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_empty (mid_empty),
		.in_item  (mid_rdata),
		.in_pop   (mid_pop),
		.out_full (res_full),
		.out_push (res_push),
		.out_row  (res_wdata)
	);

	aarm_fifo #(.WIDTH($bits(row_t)), .DEPTH(OUT_DEPTH)) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wdata),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign row_index = res_rdata.row_index;
	assign m_col0    = res_rdata.m_col0;
	assign m_col1    = res_rdata.m_col1;
	assign m_col2    = res_rdata.m_col2;
	assign offset    = res_rdata.offset;
	assign last_row  = res_rdata.last_row;
	assign bad_axis  = res_rdata.bad_axis;

endmodule

`default_nettype wire

>>> verif/rotation_checker.sv
// Checker for the axis-angle rotation matrix unit: watches both queue ports, predicts the
// three matrix rows of each accepted transaction and compares them. Depends on aarm_pkg.
`default_nettype none

module rotation_checker #(
	parameter int TRIG_ITERATIONS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  logic signed [31:0] p1_x,
	input  logic signed [31:0] p1_y,
	input  logic signed [31:0] p1_z,
	input  logic signed [31:0] p2_x,
	input  logic signed [31:0] p2_y,
	input  logic signed [31:0] p2_z,
	input  logic signed [31:0] turn_angle,
	input  logic               pop,
	input  logic               empty,
	input  logic [1:0]         row_index,
	input  logic signed [31:0] m_col0,
	input  logic signed [31:0] m_col1,
	input  logic signed [31:0] m_col2,
	input  logic signed [31:0] offset,
	input  logic               last_row,
	input  logic               bad_axis,
	output int                 failures,
	output int                 rows_pending
);
	import aarm_pkg::*;

	localparam longint ONE = 64'sd1073741824;

	row_t expected_rows[$];
	int   fail_count = 0;

	assign rows_pending = expected_rows.size();
	assign failures     = fail_count;

	function automatic longint mul_q30(longint a, longint b);
		return (a * b + (64'sd1 << 29)) >>> 30;
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint isqrt(longint unsigned n);
		longint unsigned r, bit_v;
		r = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > n)
			bit_v >>= 2;
		while (bit_v != 0) begin
			if (n >= r + bit_v) begin
				n -= r + bit_v;
				r = (r >> 1) + bit_v;
			end else begin
				r >>= 1;
			end
			bit_v >>= 2;
		end
		return longint'(r);
	endfunction

	task automatic cos_sin(input longint ang, output longint c, output longint s);
		longint z, x, y, t;
		bit flip;
		z = ang * 2;
		x = 64'sd652032874;
		y = 0;
		flip = 0;
		if (z > 64'sd1686629713) begin
			z -= 64'sd3373259426;
			flip = 1;
		end else if (z < -64'sd1686629713) begin
			z += 64'sd3373259426;
			flip = 1;
		end
		for (int i = 0; i < TRIG_ITERATIONS && i < 32; i++) begin
			if (z >= 0) begin
				t = x - (y >>> i);
				y = y + (x >>> i);
				z -= longint'(atan_q30(5'(i)));
			end else begin
				t = x + (y >>> i);
				y = y - (x >>> i);
				z += longint'(atan_q30(5'(i)));
			end
			x = t;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = clamp(x, -ONE, ONE);
		s = clamp(y, -ONE, ONE);
	endtask

	task automatic predict_rows();
		longint p[3], d[3], u[3], m[3][3];
		longint unsigned mag[3], big, sq, len;
		longint c, s, omc, uv, uw, vw, acc, t;
		bit bad;
		row_t r;
		p[0] = p1_x;
		p[1] = p1_y;
		p[2] = p1_z;
		d[0] = longint'(p2_x) - p[0];
		d[1] = longint'(p2_y) - p[1];
		d[2] = longint'(p2_z) - p[2];
		big = 0;
		for (int k = 0; k < 3; k++) begin
			mag[k] = d[k] < 0 ? -d[k] : d[k];
			if (mag[k] > big)
				big = mag[k];
		end
		bad = (big == 0);
		for (int i = 0; i < 3; i++)
			for (int k = 0; k < 3; k++)
				m[i][k] = (i == k) ? ONE : 0;
		if (!bad) begin
			while (big >= (64'd1 << 31)) begin
				big >>= 1;
				for (int k = 0; k < 3; k++) mag[k] >>= 1;
			end
			while (big < (64'd1 << 30)) begin
				big <<= 1;
				for (int k = 0; k < 3; k++) mag[k] <<= 1;
			end
			sq = 0;
			for (int k = 0; k < 3; k++)
				sq += mag[k] * mag[k];
			len = isqrt(sq);
			for (int k = 0; k < 3; k++) begin
				u[k] = longint'(((mag[k] << 30) + (len >> 1)) / len);
				if (d[k] < 0)
					u[k] = -u[k];
			end
			cos_sin(turn_angle, c, s);
			omc = ONE - c;
			uv = mul_q30(mul_q30(u[0], u[1]), omc);
			uw = mul_q30(mul_q30(u[0], u[2]), omc);
			vw = mul_q30(mul_q30(u[1], u[2]), omc);
			m[0][0] = mul_q30(mul_q30(u[0], u[0]), omc) + c;
			m[0][1] = uv - mul_q30(u[2], s);
			m[0][2] = uw + mul_q30(u[1], s);
			m[1][0] = uv + mul_q30(u[2], s);
			m[1][1] = mul_q30(mul_q30(u[1], u[1]), omc) + c;
			m[1][2] = vw - mul_q30(u[0], s);
			m[2][0] = uw - mul_q30(u[1], s);
			m[2][1] = vw + mul_q30(u[0], s);
			m[2][2] = mul_q30(mul_q30(u[2], u[2]), omc) + c;
			for (int i = 0; i < 3; i++)
				for (int k = 0; k < 3; k++)
					m[i][k] = clamp(m[i][k], -ONE, ONE);
		end
		for (int i = 0; i < 3; i++) begin
			t = 0;
			if (!bad) begin
				acc = p[i] * ONE;
				for (int k = 0; k < 3; k++)
					acc -= m[i][k] * p[k];
				t = clamp((acc + (64'sd1 << 29)) >>> 30, -64'sd2147483648, 64'sd2147483647);
			end
			r.row_index = 2'(i);
			r.m_col0 = 32'(m[i][0]);
			r.m_col1 = 32'(m[i][1]);
			r.m_col2 = 32'(m[i][2]);
			r.offset = 32'(t);
			r.last_row = (i == 2);
			r.bad_axis = bad;
			expected_rows.push_back(r);
		end
	endtask

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	always @(posedge clk) begin
		row_t e;
		if (arst_n && pop && !empty) begin
			if (expected_rows.size() == 0) begin
				report("unexpected row, index", row_index, -1);
			end else begin
				e = expected_rows.pop_front();
				if (row_index !== e.row_index) report("row_index", row_index, e.row_index);
				if (m_col0 !== e.m_col0) report("m_col0", m_col0, e.m_col0);
				if (m_col1 !== e.m_col1) report("m_col1", m_col1, e.m_col1);
				if (m_col2 !== e.m_col2) report("m_col2", m_col2, e.m_col2);
				if (offset !== e.offset) report("offset", offset, e.offset);
				if (last_row !== e.last_row) report("last_row", last_row, e.last_row);
				if (bad_axis !== e.bad_axis) report("bad_axis", bad_axis, e.bad_axis);
			end
		end
		if (arst_n && push && !full)
			predict_rows();
	end

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Top of the rotation matrix unit testbench: clock, reset, stimulus with random idling and
// the verdict. Depends on aarm_pkg, axis_angle_rotation_matrix_unit and rotation_checker.
`default_nettype none

module testbench;

	localparam int DIRECTED = 20;
	localparam int RANDOM_ITEMS = 350;
	localparam int TOTAL = DIRECTED + RANDOM_ITEMS;
	localparam int QUIET_TAIL = 60;
	localparam int IDLE_LIMIT = 20000;
	localparam int HOLD_START = 60;
	localparam int HOLD_CYCLES = 3000;
	localparam int ANGLE_MAX = 1686629713;

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic pop = 0;
	logic signed [31:0] p1_x = 0, p1_y = 0, p1_z = 0, p2_x = 0, p2_y = 0, p2_z = 0;
	logic signed [31:0] turn_angle = 0;
	logic full, empty, last_row, bad_axis;
	logic [1:0] row_index;
	logic signed [31:0] m_col0, m_col1, m_col2, offset;
	int failures, rows_pending;
	int sent = 0;
	int idle_cycles = 0;
	bit stim_done = 0;
	bit hold_done = 0;

	always #5 clk = ~clk;

	axis_angle_rotation_matrix_unit dut (.*);
	rotation_checker checker_i (.*);

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $signed($urandom_range(0, 2000)) - 1000;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic signed [31:0] rand_angle();
		case ($urandom_range(0, 7))
			0: return ANGLE_MAX;
			1: return -ANGLE_MAX;
			2: return 0;
			default: return $signed($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX;
		endcase
	endfunction

	task automatic load_item(input int n);
		logic signed [31:0] a, x1, y1, z1, x2, y2, z2, ang;
		a = rand_coord();
		x1 = rand_coord();
		y1 = rand_coord();
		z1 = rand_coord();
		x2 = rand_coord();
		y2 = rand_coord();
		z2 = rand_coord();
		ang = rand_angle();
		if (n < DIRECTED) begin
			case (n)
				0: begin x1 = 0; y1 = 0; z1 = 0; x2 = 0; y2 = 0; z2 = 0; end
				1: begin x1 = a; y1 = a; z1 = a; x2 = a; y2 = a; z2 = a; end
				2: begin x1 = 32'h8000_0000; x2 = 32'h7FFF_FFFF; end
				3: begin x1 = 32'h7FFF_FFFF; y1 = 32'h7FFF_FFFF;
					z1 = 32'h7FFF_FFFF; x2 = 32'h8000_0000;
					y2 = 32'h8000_0000; z2 = 32'h8000_0000; end
				4: begin x1 = 0; y1 = 0; z1 = 0; x2 = 0; y2 = 0; z2 = 1; end
				5: begin x1 = 5; y1 = 5; z1 = 5; x2 = 6; y2 = 5; z2 = 5; end
				6: ang = ANGLE_MAX;
				7: ang = -ANGLE_MAX;
				8: ang = 0;
				9: ang = 32'sd843314857;
				10: ang = -32'sd843314857;
				11: ang = 32'h7FFF_FFFF;
				12: ang = 32'h8000_0000;
				default: ;
			endcase
		end else if ($urandom_range(0, 9) == 0) begin
			x2 = a; x1 = a;
			y2 = y1; z2 = z1;
		end
		p1_x <= x1;
		p1_y <= y1;
		p1_z <= z1;
		p2_x <= x2;
		p2_y <= y2;
		p2_z <= z2;
		turn_angle <= ang;
	endtask

	always @(posedge clk) begin
		if (stim_done && rows_pending == 0) begin
		end else if ((push && !full) || (pop && !empty)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int gap;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		load_item(0);
		push <= 1;
		while (sent < TOTAL) begin
			@(posedge clk);
			if (push && !full) begin
				sent++;
				if (sent < TOTAL) begin
					gap = (sent < TOTAL - 60 && $urandom_range(0, 3) == 0) ?
						$urandom_range(1, 19) : 0;
					if (gap > 0) begin
						push <= 0;
						repeat (gap) @(posedge clk);
					end
					load_item(sent);
					push <= 1;
				end else begin
					push <= 0;
				end
			end
		end
		stim_done = 1;
	end

	initial begin
		int gap;
		repeat (12) @(posedge clk);
		repeat (HOLD_START) @(posedge clk);
		pop <= 1;
		while (!stim_done) begin
			@(posedge clk);
			if (sent >= TOTAL - 60) begin
				pop <= 1;
			end else if (!hold_done && sent >= 40) begin
				hold_done = 1;
				pop <= 0;
				repeat (HOLD_CYCLES) @(posedge clk);
				pop <= 1;
			end else if ($urandom_range(0, 3) == 0) begin
				gap = $urandom_range(1, 19);
				pop <= 0;
				repeat (gap) @(posedge clk);
				pop <= 1;
			end
		end
		pop <= 1;
		while (rows_pending != 0) @(posedge clk);
		repeat (QUIET_TAIL) @(posedge clk);
		if (failures == 0 && rows_pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
design/aarm_pkg.sv
design/aarm_fifo.sv
design/aarm_front.sv
design/aarm_cordic.sv
design/aarm_back.sv
design/axis_angle_rotation_matrix_unit.sv
verif/rotation_checker.sv
verif/testbench.sv
